// ===== design/mba_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and saturating helpers for the memory budget admission core.
// No dependencies; every other design file imports this package.
package mba_pkg;

  localparam int BW          = 48;
  localparam int SLOT_W      = 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = BW;
  localparam int CMD_W       = 2;
  localparam int CLS_W       = 3;
  localparam int FIFO_AW     = 1;
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;

  localparam int IN_FIELDS_W  = 2 + 3 * BW;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = CMD_W + CLS_W;
  localparam int OUT_FIELDS_W = 1 + 2 * BW;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [BW-1:0]     bytes_t;
  typedef logic [SLOT_W-1:0] slots_t;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VALIDATE = 2'd2;

  localparam logic [CLS_W-1:0] CLS_IO      = 3'd0;
  localparam logic [CLS_W-1:0] CLS_PREPARE = 3'd1;
  localparam logic [CLS_W-1:0] CLS_PUBLISH = 3'd2;
  localparam logic [CLS_W-1:0] CLS_EXECUTE = 3'd3;

  localparam logic [CFG_AW-1:0] REG_GLOBAL_BUDGET    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RESERVED_CRIT    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IO_BUDGET        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_PREP_BUDGET      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PREPARED_BUDGET  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_EXEC_BUDGET      = 3'd5;
  localparam logic [CFG_AW-1:0] REG_IO_SLOTS         = 3'd6;

  typedef struct packed {
    bytes_t global_budget;
    bytes_t reserved_critical;
    bytes_t io_budget;
    bytes_t preparation_budget;
    bytes_t prepared_budget;
    bytes_t execution_budget;
    slots_t io_slots;
  } cfg_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             is_io;
    logic             fits_whole;
    slots_t           io_lim;
    bytes_t           cap_glob;
    bytes_t           d_glob;
    bytes_t           d_io;
    bytes_t           d_prep;
    bytes_t           d_pred;
    bytes_t           d_exec;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    bytes_t peak;
    bytes_t total;
    logic   granted;
  } res_t;

  function automatic bytes_t sat_add(bytes_t a, bytes_t b);
    logic [BW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BW] ? '1 : s[BW-1:0];
  endfunction

  function automatic bytes_t sat_sub(bytes_t a, bytes_t b);
    return (a > b) ? bytes_t'(a - b) : '0;
  endfunction

endpackage

// ===== design/memory_budget_admission_core.sv =====
`timescale 1ns / 1ps
// An accepted request is queued, then popped into the back-end result register and offered on out.
// Throughput: one request per cycle while out_tready is high; the back end updates its counters on each pop.
// A two-entry queue absorbs two requests while a result waits on out_tready.
// Reset (rst_n low, synchronous) zeroes all counters and budgets and sets io_slots to 1.
// Depends on mba_pkg, mba_front, mba_fifo, mba_back.
module memory_budget_admission_core import mba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // is_critical, critical_waiting, in_bytes, out_bytes, temp_bytes, zero fill
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // cmd, task_class
  input  logic [IN_TUSER_W-1:0]   in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // granted, global_total, global_peak, zero fill
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_DW-1:0]       cfg_wdata
);

  cfg_t       cfg_r;
  entry_t     f_entry;
  entry_t     q_entry;
  fifo_stat_t q_stat;
  logic       q_push;
  logic       q_pop;
  res_t       out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // io_slots sits in the lowest bits of the register bank
      cfg_r <= cfg_t'({(6*BW)'(0), slots_t'(1)});
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GLOBAL_BUDGET:   cfg_r.global_budget      <= cfg_wdata[BW-1:0];
        REG_RESERVED_CRIT:   cfg_r.reserved_critical  <= cfg_wdata[BW-1:0];
        REG_IO_BUDGET:       cfg_r.io_budget          <= cfg_wdata[BW-1:0];
        REG_PREP_BUDGET:     cfg_r.preparation_budget <= cfg_wdata[BW-1:0];
        REG_PREPARED_BUDGET: cfg_r.prepared_budget    <= cfg_wdata[BW-1:0];
        REG_EXEC_BUDGET:     cfg_r.execution_budget   <= cfg_wdata[BW-1:0];
        REG_IO_SLOTS:        cfg_r.io_slots           <= cfg_wdata[SLOT_W-1:0];
        default:             ;
      endcase
    end
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  mba_front u_front (
    .cfg              (cfg_r),
    .cmd              (in_tuser[CMD_W-1:0]),
    .task_class       (in_tuser[CMD_W+CLS_W-1:CMD_W]),
    .is_critical      (in_tdata[0]),
    .critical_waiting (in_tdata[1]),
    .in_bytes         (in_tdata[2+BW-1:2]),
    .out_bytes        (in_tdata[2+2*BW-1:2+BW]),
    .temp_bytes       (in_tdata[2+3*BW-1:2+2*BW]),
    .entry            (f_entry)
  );

  mba_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (f_entry),
    .pop   (q_pop),
    .rdata (q_entry),
    .stat  (q_stat)
  );

  mba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .entry     (q_entry),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (out_res)
  );

  assign out_tdata = OUT_TDATA_W'({out_res.peak, out_res.total, out_res.granted});

  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.peak >= out_res.total))
    else $error("peak below current total");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("input accepted while queue full");

  a_pop_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid)
    else $error("popped request produced no result");

endmodule

// ===== design/mba_front.sv =====
`timescale 1ns / 1ps
// Front end: forms per-pool demands, caps and the whole-budget check for one request.
// Depends on mba_pkg.
module mba_front import mba_pkg::*; (
  input  cfg_t             cfg,
  input  logic [CMD_W-1:0] cmd,
  input  logic [CLS_W-1:0] task_class,
  input  logic             is_critical,
  input  logic             critical_waiting,
  input  bytes_t           in_bytes,
  input  bytes_t           out_bytes,
  input  bytes_t           temp_bytes,
  output entry_t           entry
);

  logic   spec;
  bytes_t d_glob;
  bytes_t d_io;
  bytes_t d_prep;
  bytes_t d_pred;
  bytes_t d_exec;
  slots_t slots_less;

  assign d_glob = sat_add(sat_add(in_bytes, out_bytes), temp_bytes);

  always_comb begin
    d_io   = '0;
    d_prep = '0;
    d_pred = '0;
    d_exec = '0;
    unique case (task_class)
      CLS_IO:      d_io = d_glob;
      CLS_PREPARE: begin
        d_prep = sat_add(in_bytes, temp_bytes);
        d_pred = out_bytes;
      end
      CLS_PUBLISH: d_pred = d_glob;
      CLS_EXECUTE: d_exec = d_glob;
      default:     ;
    endcase
  end

  // Non-critical work while critical work is pending gives up a slot and the reserve.
  assign spec       = !is_critical && critical_waiting;
  assign slots_less = (cfg.io_slots != '0) ? slots_t'(cfg.io_slots - 1'b1) : '0;

  always_comb begin
    entry.cmd        = cmd;
    entry.is_io      = (task_class == CLS_IO);
    entry.io_lim     = spec ? slots_less : cfg.io_slots;
    entry.cap_glob   = spec ? sat_sub(cfg.global_budget, cfg.reserved_critical)
                            : cfg.global_budget;
    entry.fits_whole = (d_glob <= cfg.global_budget) && (d_io <= cfg.io_budget) &&
                       (d_prep <= cfg.preparation_budget) &&
                       (d_pred <= cfg.prepared_budget) &&
                       (d_exec <= cfg.execution_budget);
    entry.d_glob     = d_glob;
    entry.d_io       = d_io;
    entry.d_prep     = d_prep;
    entry.d_pred     = d_pred;
    entry.d_exec     = d_exec;
  end

endmodule

// ===== design/mba_fifo.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on mba_pkg.
module mba_fifo import mba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  entry_t     wdata,
  input  logic       pop,
  output entry_t     rdata,
  output fifo_stat_t stat
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/mba_back.sv =====
`timescale 1ns / 1ps
// Back end: checks room in every pool, updates the in-use counters and
// holds the result register. Depends on mba_pkg.
module mba_back import mba_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  entry_t entry,
  input  logic   q_empty,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   res
);

  bytes_t glob_r, io_r, prep_r, pred_r, exec_r, peak_r;
  bytes_t glob_nxt, io_nxt, prep_nxt, pred_nxt, exec_nxt, peak_nxt;
  slots_t io_act_r, io_act_nxt;
  logic   out_valid_r;
  res_t   res_r;
  logic   fits;
  logic   slot_ok;
  logic   admit;
  logic   granted;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  // Class caps come from cfg; the user must change cfg only while idle, unenforced.
  assign fits = (entry.d_glob <= sat_sub(entry.cap_glob, glob_r)) &&
                (entry.d_io   <= sat_sub(cfg.io_budget, io_r)) &&
                (entry.d_prep <= sat_sub(cfg.preparation_budget, prep_r)) &&
                (entry.d_pred <= sat_sub(cfg.prepared_budget, pred_r)) &&
                (entry.d_exec <= sat_sub(cfg.execution_budget, exec_r));

  assign slot_ok = !entry.is_io || (io_act_r < entry.io_lim);
  assign admit   = fits && slot_ok;

  always_comb begin
    glob_nxt   = glob_r;
    io_nxt     = io_r;
    prep_nxt   = prep_r;
    pred_nxt   = pred_r;
    exec_nxt   = exec_r;
    io_act_nxt = io_act_r;
    granted    = 1'b0;
    unique case (entry.cmd)
      CMD_ACQUIRE: begin
        granted = admit;
        if (admit) begin
          glob_nxt = sat_add(glob_r, entry.d_glob);
          io_nxt   = sat_add(io_r, entry.d_io);
          prep_nxt = sat_add(prep_r, entry.d_prep);
          pred_nxt = sat_add(pred_r, entry.d_pred);
          exec_nxt = sat_add(exec_r, entry.d_exec);
          if (entry.is_io && (io_act_r != '1)) begin
            io_act_nxt = io_act_r + 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        granted  = 1'b1;
        glob_nxt = sat_sub(glob_r, entry.d_glob);
        io_nxt   = sat_sub(io_r, entry.d_io);
        prep_nxt = sat_sub(prep_r, entry.d_prep);
        pred_nxt = sat_sub(pred_r, entry.d_pred);
        exec_nxt = sat_sub(exec_r, entry.d_exec);
        if (entry.is_io && (io_act_r != '0)) begin
          io_act_nxt = io_act_r - 1'b1;
        end
      end
      CMD_VALIDATE: granted = entry.fits_whole;
      default:      granted = 1'b0;
    endcase
    peak_nxt = (glob_nxt > peak_r) ? glob_nxt : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r      <= '0;
      io_r        <= '0;
      prep_r      <= '0;
      pred_r      <= '0;
      exec_r      <= '0;
      peak_r      <= '0;
      io_act_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      glob_r      <= glob_nxt;
      io_r        <= io_nxt;
      prep_r      <= prep_nxt;
      pred_r      <= pred_nxt;
      exec_r      <= exec_nxt;
      peak_r      <= peak_nxt;
      io_act_r    <= io_act_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.granted <= granted;
      res_r.total   <= glob_nxt;
      res_r.peak    <= peak_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
